[src/iacf_pkg.sv]
`default_nettype none
package iacf_pkg;

	localparam int SENSOR_SLOTS = 8;
	localparam int CAL_SAMPLES  = 25;
	localparam int SLOT_W       = 3;
	localparam int IDX_W        = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
	localparam int PHASE_W      = 6;
	localparam int BIAS_W       = 22;
	localparam int STEP_W       = 5;
	localparam int SQRT_STEPS   = 32;
	localparam int CORDIC_STEPS = 30;

	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(CAL_SAMPLES);

	// bias = floor((sum*128 + N) / (2N)) via reciprocal and one correction
	localparam int          BIAS_DIV      = 2 * CAL_SAMPLES;
	localparam logic [29:0] BIAS_DIV_W    = 30'(BIAS_DIV);
	localparam logic [29:0] BIAS_RECIP    = 30'((64'd1 << 30) / BIAS_DIV);
	localparam logic [29:0] BIAS_ROUND    = 30'(CAL_SAMPLES);

	localparam logic [1:0] REG_ACCEL_WEIGHT = 2'd0;
	localparam logic [1:0] REG_BLEND_WEIGHT = 2'd1;
	localparam logic [1:0] REG_GYRO_SCALE   = 2'd2;

	localparam logic [15:0] ACCEL_WEIGHT_RST = 16'd45875;
	localparam logic [15:0] BLEND_WEIGHT_RST = 16'd19661;
	localparam logic [31:0] GYRO_SCALE_RST   = 32'd709486;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQRT_INIT,
		OP_SQRT,
		OP_CORDIC_INIT,
		OP_CORDIC,
		OP_SEED,
		OP_CAL,
		OP_BIAS_MUL,
		OP_BIAS_FIX,
		OP_MIXA_MUL,
		OP_MIXA_SUM,
		OP_INC_MUL,
		OP_MIXB_MUL,
		OP_FINAL
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic slot_ok;
		logic unseeded;
		logic calib;
		logic cal_last;
	} stat_t;

	// atan(2^-i) in Q2.30
	function automatic logic [29:0] atan_entry(input logic [STEP_W-1:0] i);
		logic [29:0] v;
		unique case (i)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043837;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543516;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048576;
			5'd11: v = 30'd524288;
			5'd12: v = 30'd262144;
			5'd13: v = 30'd131072;
			5'd14: v = 30'd65536;
			5'd15: v = 30'd32768;
			5'd16: v = 30'd16384;
			5'd17: v = 30'd8192;
			5'd18: v = 30'd4096;
			5'd19: v = 30'd2048;
			5'd20: v = 30'd1024;
			5'd21: v = 30'd512;
			5'd22: v = 30'd256;
			5'd23: v = 30'd128;
			5'd24: v = 30'd64;
			5'd25: v = 30'd32;
			5'd26: v = 30'd16;
			5'd27: v = 30'd8;
			5'd28: v = 30'd4;
			5'd29: v = 30'd2;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
		logic signed [31:0] r;
		if (v > 56'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -56'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

[src/imu_complementary_attitude_filter_core.sv]
// A running-phase word passes through 32 root steps and 30 CORDIC steps, both axes in
// parallel, then the mix stages, before m_tvalid rises; FINAL waits for a free output.
// The core takes one word at a time, for running, seeding and calibration alike.
// Results sit in an output register, so the next word may enter while one waits.
// arst_n clears all slot phases, biases and fused angles and loads register defaults.
`default_nettype none
module imu_complementary_attitude_filter_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [95:0]  s_tdata,  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
	input  wire [2:0]   s_tuser,  // sensor_slot
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [95:0] m_tdata,  // roll_angle, pitch_angle, yaw_angle
	output logic [2:0]  m_tuser,  // result_slot
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire [3:0]   paddr,
	input  wire [31:0]  pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import iacf_pkg::*;

	logic [15:0] accel_weight_q;
	logic [15:0] blend_weight_q;
	logic [31:0] gyro_scale_q;
	cmd_t        cmd;
	stat_t       stat;
	logic signed [31:0] roll_angle;
	logic signed [31:0] pitch_angle;
	logic signed [31:0] yaw_angle;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_weight_q <= ACCEL_WEIGHT_RST;
			blend_weight_q <= BLEND_WEIGHT_RST;
			gyro_scale_q   <= GYRO_SCALE_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_ACCEL_WEIGHT: accel_weight_q <= pwdata[15:0];
				REG_BLEND_WEIGHT: blend_weight_q <= pwdata[15:0];
				REG_GYRO_SCALE:   gyro_scale_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ACCEL_WEIGHT: prdata = {16'd0, accel_weight_q};
			REG_BLEND_WEIGHT: prdata = {16'd0, blend_weight_q};
			REG_GYRO_SCALE:   prdata = gyro_scale_q;
			default:          prdata = '0;
		endcase
	end

	iacf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	iacf_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.sensor_slot  (s_tuser),
		.accel_x      (s_tdata[15:0]),
		.accel_y      (s_tdata[31:16]),
		.accel_z      (s_tdata[47:32]),
		.gyro_x       (s_tdata[63:48]),
		.gyro_y       (s_tdata[79:64]),
		.gyro_z       (s_tdata[95:80]),
		.accel_weight (accel_weight_q),
		.blend_weight (blend_weight_q),
		.gyro_scale   (gyro_scale_q),
		.result_slot  (m_tuser),
		.roll_angle   (roll_angle),
		.pitch_angle  (pitch_angle),
		.yaw_angle    (yaw_angle)
	);

	assign m_tdata = {yaw_angle, pitch_angle, roll_angle};

endmodule
`default_nettype wire

[src/iacf_ctrl.sv]
`default_nettype none
module iacf_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire                 m_tready,
	input  iacf_pkg::stat_t     stat,
	output iacf_pkg::cmd_t      cmd
);
	import iacf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_SQRT_INIT,
		S_SQRT,
		S_CORDIC_INIT,
		S_CORDIC,
		S_SEED,
		S_CAL,
		S_BIAS_MUL,
		S_BIAS_FIX,
		S_MIXA_MUL,
		S_MIXA_SUM,
		S_INC_MUL,
		S_MIXB_MUL,
		S_FINAL
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] cnt_q;
	logic              run_q;
	logic              m_tvalid_q;
	logic              out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd.step = cnt_q;
		unique case (state_q)
			S_IDLE:        cmd.op = s_tvalid ? OP_LOAD : OP_NONE;
			S_LOAD:        cmd.op = OP_NONE;
			S_SQRT_INIT:   cmd.op = OP_SQRT_INIT;
			S_SQRT:        cmd.op = OP_SQRT;
			S_CORDIC_INIT: cmd.op = OP_CORDIC_INIT;
			S_CORDIC:      cmd.op = OP_CORDIC;
			S_SEED:        cmd.op = OP_SEED;
			S_CAL:         cmd.op = OP_CAL;
			S_BIAS_MUL:    cmd.op = OP_BIAS_MUL;
			S_BIAS_FIX:    cmd.op = OP_BIAS_FIX;
			S_MIXA_MUL:    cmd.op = OP_MIXA_MUL;
			S_MIXA_SUM:    cmd.op = OP_MIXA_SUM;
			S_INC_MUL:     cmd.op = OP_INC_MUL;
			S_MIXB_MUL:    cmd.op = OP_MIXB_MUL;
			S_FINAL:       cmd.op = out_free ? OP_FINAL : OP_NONE;
			default:       cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			run_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_FINAL && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid)
						state_q <= S_LOAD;
				end
				S_LOAD: begin
					priority if (!stat.slot_ok)
						state_q <= S_IDLE;
					else if (stat.unseeded) begin
						run_q   <= 1'b0;
						state_q <= S_SQRT_INIT;
					end else if (stat.calib)
						state_q <= S_CAL;
					else begin
						run_q   <= 1'b1;
						state_q <= S_SQRT_INIT;
					end
				end
				S_SQRT_INIT: begin
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(SQRT_STEPS - 1))
						state_q <= S_CORDIC_INIT;
				end
				S_CORDIC_INIT: begin
					cnt_q   <= '0;
					state_q <= S_CORDIC;
				end
				S_CORDIC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(CORDIC_STEPS - 1))
						state_q <= run_q ? S_MIXA_MUL : S_SEED;
				end
				S_SEED:     state_q <= S_IDLE;
				S_CAL:      state_q <= stat.cal_last ? S_BIAS_MUL : S_IDLE;
				S_BIAS_MUL: state_q <= S_BIAS_FIX;
				S_BIAS_FIX: state_q <= S_IDLE;
				S_MIXA_MUL: state_q <= S_MIXA_SUM;
				S_MIXA_SUM: state_q <= S_INC_MUL;
				S_INC_MUL:  state_q <= S_MIXB_MUL;
				S_MIXB_MUL: state_q <= S_FINAL;
				S_FINAL: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[src/iacf_datapath.sv]
`default_nettype none
module iacf_datapath (
	input  wire                          clk,
	input  wire                          arst_n,
	input  iacf_pkg::cmd_t               cmd,
	output iacf_pkg::stat_t              stat,
	input  wire [iacf_pkg::SLOT_W-1:0]   sensor_slot,
	input  wire signed [15:0]            accel_x,
	input  wire signed [15:0]            accel_y,
	input  wire signed [15:0]            accel_z,
	input  wire signed [15:0]            gyro_x,
	input  wire signed [15:0]            gyro_y,
	input  wire signed [15:0]            gyro_z,
	input  wire [15:0]                   accel_weight,
	input  wire [15:0]                   blend_weight,
	input  wire [31:0]                   gyro_scale,
	output logic [iacf_pkg::SLOT_W-1:0]  result_slot,
	output logic signed [31:0]           roll_angle,
	output logic signed [31:0]           pitch_angle,
	output logic signed [31:0]           yaw_angle
);
	import iacf_pkg::*;

	logic [SLOT_W-1:0]  slot_q;
	logic signed [15:0] acc_q [3];
	logic signed [15:0] gyr_q [3];
	logic [IDX_W-1:0]   idx;

	logic [PHASE_W-1:0]       phase_q [SENSOR_SLOTS];
	logic signed [BIAS_W-1:0] bias_q  [3][SENSOR_SLOTS];
	logic signed [31:0]       fused_q [3][SENSOR_SLOTS];
	logic signed [31:0]       lp_q    [2][SENSOR_SLOTS];

	// lane 0 roll, lane 1 pitch
	logic signed [15:0] num [2];
	logic signed [15:0] opa [2];
	logic [31:0]        sq  [2];
	logic [63:0]        n_q    [2];
	logic [34:0]        rem_q  [2];
	logic [31:0]        root_q [2];
	logic [34:0]        rem_sh [2];
	logic [34:0]        trial  [2];
	logic signed [35:0] x_q [2];
	logic signed [35:0] y_q [2];
	logic signed [32:0] z_q [2];
	logic signed [35:0] dx  [2];
	logic signed [35:0] dy  [2];
	logic signed [32:0] da  [2];
	logic signed [32:0] zr  [2];
	logic signed [31:0] ang [2];

	logic signed [55:0] pa1 [2];
	logic signed [55:0] pa2 [2];
	logic signed [55:0] pa1_q [2];
	logic signed [55:0] pa2_q [2];
	logic signed [31:0] lpn [2];
	logic signed [31:0] lpn_q [2];
	logic signed [17:0] wca;
	logic signed [17:0] wcb;

	logic signed [BIAS_W-1:0] csum [3];
	logic signed [29:0]       bv   [3];
	logic [29:0]              bn   [3];
	logic [29:0]              bn_q [3];
	logic                     bneg_q [3];
	logic [59:0]              bprod [3];
	logic [29:0]              bq_q  [3];
	logic [29:0]              brem  [3];
	logic [29:0]              bqc   [3];
	logic signed [BIAS_W-1:0] bres  [3];

	logic signed [22:0] rate  [3];
	logic signed [55:0] gprod [3];
	logic signed [55:0] gprod_q [3];
	logic signed [55:0] inc   [3];
	logic signed [55:0] bsum  [2];
	logic signed [55:0] pb1   [2];
	logic signed [55:0] pb2   [2];
	logic signed [55:0] pb1_q [2];
	logic signed [55:0] pb2_q [2];
	logic signed [55:0] yaw_sum;
	logic signed [55:0] yaw_q;
	logic signed [31:0] fnew  [2];

	assign idx = IDX_W'(slot_q);

	assign stat.slot_ok  = int'(slot_q) < SENSOR_SLOTS;
	assign stat.unseeded = (phase_q[idx] == '0);
	assign stat.calib    = (phase_q[idx] != '0) && (phase_q[idx] <= PHASE_LAST);
	assign stat.cal_last = (phase_q[idx] == PHASE_LAST);

	assign num[0] = acc_q[1];
	assign opa[0] = acc_q[0];
	assign num[1] = acc_q[0];
	assign opa[1] = acc_q[1];

	assign wca = 18'sh10000 - $signed({2'b00, accel_weight});
	assign wcb = 18'sh10000 - $signed({2'b00, blend_weight});

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			sq[l]     = 32'(opa[l]) * 32'(opa[l]) + 32'(acc_q[2]) * 32'(acc_q[2]);
			rem_sh[l] = {rem_q[l][32:0], n_q[l][63:62]};
			trial[l]  = {1'b0, root_q[l], 2'b01};
			dx[l]     = x_q[l] >>> cmd.step;
			dy[l]     = y_q[l] >>> cmd.step;
			da[l]     = $signed({3'b000, atan_entry(cmd.step)});
			zr[l]     = (z_q[l] + 33'sd8192) >>> 14;
			ang[l]    = zr[l][31:0];
			pa1[l]    = $signed({1'b0, accel_weight}) * ang[l];
			pa2[l]    = wca * lp_q[l][idx];
			lpn[l]    = sat32((pa1_q[l] + pa2_q[l] + 56'sd32768) >>> 16);
		end
		for (int k = 0; k < 3; k++) begin
			csum[k]  = bias_q[k][idx] + BIAS_W'(gyr_q[k]);
			bv[k]    = (30'(csum[k]) <<< 7) + $signed(BIAS_ROUND);
			bn[k]    = bv[k][29] ? (30'(-bv[k]) + BIAS_DIV_W - 30'd1) : bv[k];
			bprod[k] = bn_q[k] * BIAS_RECIP;
			brem[k]  = bn_q[k] - 30'(bq_q[k] * BIAS_DIV_W);
			bqc[k]   = (brem[k] >= BIAS_DIV_W) ? bq_q[k] + 30'd1 : bq_q[k];
			bres[k]  = bneg_q[k] ? -BIAS_W'(bqc[k]) : BIAS_W'(bqc[k]);
			rate[k]  = (23'(gyr_q[k]) <<< 6) - 23'(bias_q[k][idx]);
			gprod[k] = rate[k] * $signed({1'b0, gyro_scale});
			inc[k]   = (gprod_q[k] + 56'sd2097152) >>> 22;
		end
		for (int l = 0; l < 2; l++) begin
			bsum[l] = 56'(fused_q[l][idx]) + inc[l];
			pb1[l]  = $signed({1'b0, blend_weight}) * lpn_q[l];
			pb2[l]  = wcb * bsum[l];
			fnew[l] = sat32((pb1_q[l] + pb2_q[l] + 56'sd32768) >>> 16);
		end
		yaw_sum = 56'(fused_q[2][idx]) + inc[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SENSOR_SLOTS; s++) begin
				phase_q[s] <= '0;
				for (int k = 0; k < 3; k++) begin
					bias_q[k][s]  <= '0;
					fused_q[k][s] <= '0;
				end
			end
		end else begin
			unique case (cmd.op)
				OP_SEED: begin
					phase_q[idx] <= PHASE_W'(1);
					for (int k = 0; k < 3; k++) begin
						bias_q[k][idx]  <= '0;
						fused_q[k][idx] <= '0;
					end
				end
				OP_CAL: begin
					phase_q[idx] <= phase_q[idx] + 1'b1;
					for (int k = 0; k < 3; k++)
						bias_q[k][idx] <= csum[k];
				end
				OP_BIAS_FIX: begin
					for (int k = 0; k < 3; k++)
						bias_q[k][idx] <= bres[k];
				end
				OP_FINAL: begin
					fused_q[0][idx] <= fnew[0];
					fused_q[1][idx] <= fnew[1];
					fused_q[2][idx] <= sat32(yaw_q);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				slot_q   <= sensor_slot;
				acc_q[0] <= accel_x;
				acc_q[1] <= accel_y;
				acc_q[2] <= accel_z;
				gyr_q[0] <= gyro_x;
				gyr_q[1] <= gyro_y;
				gyr_q[2] <= gyro_z;
			end
			OP_SQRT_INIT: begin
				for (int l = 0; l < 2; l++) begin
					n_q[l]    <= {sq[l], 32'd0};
					rem_q[l]  <= '0;
					root_q[l] <= '0;
				end
			end
			OP_SQRT: begin
				for (int l = 0; l < 2; l++) begin
					n_q[l] <= {n_q[l][61:0], 2'b00};
					if (rem_sh[l] >= trial[l]) begin
						rem_q[l]  <= rem_sh[l] - trial[l];
						root_q[l] <= {root_q[l][30:0], 1'b1};
					end else begin
						rem_q[l]  <= rem_sh[l];
						root_q[l] <= {root_q[l][30:0], 1'b0};
					end
				end
			end
			OP_CORDIC_INIT: begin
				for (int l = 0; l < 2; l++) begin
					x_q[l] <= $signed({4'b0000, root_q[l]});
					y_q[l] <= 36'(num[l]) <<< 16;
					z_q[l] <= '0;
				end
			end
			OP_CORDIC: begin
				for (int l = 0; l < 2; l++) begin
					if (y_q[l] > 36'sd0) begin
						x_q[l] <= x_q[l] + dy[l];
						y_q[l] <= y_q[l] - dx[l];
						z_q[l] <= z_q[l] + da[l];
					end else if (y_q[l] < 36'sd0) begin
						x_q[l] <= x_q[l] - dy[l];
						y_q[l] <= y_q[l] + dx[l];
						z_q[l] <= z_q[l] - da[l];
					end
				end
			end
			OP_SEED: begin
				for (int l = 0; l < 2; l++)
					lp_q[l][idx] <= ang[l];
			end
			OP_CAL: begin
				for (int k = 0; k < 3; k++) begin
					bn_q[k]   <= bn[k];
					bneg_q[k] <= bv[k][29];
				end
			end
			OP_BIAS_MUL: begin
				for (int k = 0; k < 3; k++)
					bq_q[k] <= bprod[k][59:30];
			end
			OP_MIXA_MUL: begin
				for (int l = 0; l < 2; l++) begin
					pa1_q[l] <= pa1[l];
					pa2_q[l] <= pa2[l];
				end
			end
			OP_MIXA_SUM: begin
				for (int l = 0; l < 2; l++) begin
					lpn_q[l]     <= lpn[l];
					lp_q[l][idx] <= lpn[l];
				end
			end
			OP_INC_MUL: begin
				for (int k = 0; k < 3; k++)
					gprod_q[k] <= gprod[k];
			end
			OP_MIXB_MUL: begin
				for (int l = 0; l < 2; l++) begin
					pb1_q[l] <= pb1[l];
					pb2_q[l] <= pb2[l];
				end
				yaw_q <= yaw_sum;
			end
			OP_FINAL: begin
				result_slot <= slot_q;
				roll_angle  <= fnew[0];
				pitch_angle <= fnew[1];
				yaw_angle   <= sat32(yaw_q);
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[tb/sv/iacf_checker.sv]
`timescale 1ns / 100ps
module iacf_checker
	import iacf_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	input  wire        s_tready,
	input  wire [95:0] s_tdata,
	input  wire [2:0]  s_tuser,
	input  wire        m_tvalid,
	input  wire        m_tready,
	input  wire [95:0] m_tdata,
	input  wire [2:0]  m_tuser,
	input  wire        psel,
	input  wire        penable,
	input  wire        pwrite,
	input  wire [3:0]  paddr,
	input  wire [31:0] pwdata,
	output int         fail_count,
	output int         pending
);

	typedef struct packed {
		logic [2:0]         slot;
		logic signed [31:0] roll;
		logic signed [31:0] pitch;
		logic signed [31:0] yaw;
	} angles_t;

	angles_t angle_q[$];

	logic [15:0] w_accel;
	logic [15:0] w_blend;
	logic [31:0] g_scale;
	int unsigned phase_mem [SENSOR_SLOTS];
	longint bias_x [SENSOR_SLOTS];
	longint bias_y [SENSOR_SLOTS];
	longint bias_z [SENSOR_SLOTS];
	longint lp_roll [SENSOR_SLOTS];
	longint lp_pitch [SENSOR_SLOTS];
	longint att_roll [SENSOR_SLOTS];
	longint att_pitch [SENSOR_SLOTS];
	longint att_yaw [SENSOR_SLOTS];

	function automatic longint sat_q16(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint isqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint tilt_angle(longint num, longint a, longint b);
		longint unsigned sq;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		longint tab [30];
		tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
			16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
			65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
			16, 8, 4, 2};
		sq = longint'(a * a) + longint'(b * b);
		x = isqrt(sq << 32);
		y = num * 65536;
		z = 0;
		for (int i = 0; i < 30; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y > 0) begin
				x += dy;
				y -= dx;
				z += tab[i];
			end else if (y < 0) begin
				x -= dy;
				y += dx;
				z -= tab[i];
			end
		end
		return sat_q16((z + 8192) >>> 14);
	endfunction

	function automatic longint blend(longint w, longint a, longint b);
		return (w * a + (65536 - w) * b + 32768) >>> 16;
	endfunction

	function automatic longint rate_step(longint g, longint bias);
		longint rate;
		rate = g * 64 - bias;
		return (rate * longint'(g_scale) + (64'sd1 << 21)) >>> 22;
	endfunction

	function automatic longint bias_of(longint sum);
		longint num;
		longint q;
		num = sum * 128 + CAL_SAMPLES;
		q = num / (2 * CAL_SAMPLES);
		if (num % (2 * CAL_SAMPLES) != 0 && num < 0)
			q--;
		return q;
	endfunction

	task automatic track_sample(logic [2:0] s, logic [95:0] d);
		longint ax;
		longint ay;
		longint az;
		longint gx;
		longint gy;
		longint gz;
		angles_t res;
		ax = longint'($signed(d[15:0]));
		ay = longint'($signed(d[31:16]));
		az = longint'($signed(d[47:32]));
		gx = longint'($signed(d[63:48]));
		gy = longint'($signed(d[79:64]));
		gz = longint'($signed(d[95:80]));
		if (phase_mem[s] == 0) begin
			lp_roll[s] = tilt_angle(ay, ax, az);
			lp_pitch[s] = tilt_angle(ax, ay, az);
			bias_x[s] = 0;
			bias_y[s] = 0;
			bias_z[s] = 0;
			att_roll[s] = 0;
			att_pitch[s] = 0;
			att_yaw[s] = 0;
			phase_mem[s] = 1;
		end else if (phase_mem[s] <= CAL_SAMPLES) begin
			bias_x[s] += gx;
			bias_y[s] += gy;
			bias_z[s] += gz;
			if (phase_mem[s] == CAL_SAMPLES) begin
				bias_x[s] = bias_of(bias_x[s]);
				bias_y[s] = bias_of(bias_y[s]);
				bias_z[s] = bias_of(bias_z[s]);
			end
			phase_mem[s]++;
		end else begin
			lp_roll[s] = sat_q16(blend(w_accel, tilt_angle(ay, ax, az), lp_roll[s]));
			lp_pitch[s] = sat_q16(blend(w_accel, tilt_angle(ax, ay, az), lp_pitch[s]));
			att_roll[s] = sat_q16(blend(w_blend, lp_roll[s],
				att_roll[s] + rate_step(gx, bias_x[s])));
			att_pitch[s] = sat_q16(blend(w_blend, lp_pitch[s],
				att_pitch[s] + rate_step(gy, bias_y[s])));
			att_yaw[s] = sat_q16(att_yaw[s] + rate_step(gz, bias_z[s]));
			res.slot = s;
			res.roll = att_roll[s][31:0];
			res.pitch = att_pitch[s][31:0];
			res.yaw = att_yaw[s][31:0];
			angle_q.insert(angle_q.size(), res);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		angles_t exp_r;
		angles_t got;
		if (!arst_n) begin
			w_accel <= ACCEL_WEIGHT_RST;
			w_blend <= BLEND_WEIGHT_RST;
			g_scale <= GYRO_SCALE_RST;
			for (int i = 0; i < SENSOR_SLOTS; i++)
				phase_mem[i] = 0;
			angle_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
					REG_ACCEL_WEIGHT: w_accel <= pwdata[15:0];
					REG_BLEND_WEIGHT: w_blend <= pwdata[15:0];
					REG_GYRO_SCALE: g_scale <= pwdata;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.slot = m_tuser;
				got.roll = m_tdata[31:0];
				got.pitch = m_tdata[63:32];
				got.yaw = m_tdata[95:64];
				if (angle_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected word: slot %0d %h", m_tuser, m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = angle_q.pop_front();
					if (got !== exp_r) begin
						if (fail_count < 10)
							$display("mismatch slot %0d/%0d roll %0d/%0d pitch %0d/%0d yaw %0d/%0d (exp/act)",
								exp_r.slot, got.slot, exp_r.roll, got.roll,
								exp_r.pitch, got.pitch, exp_r.yaw, got.yaw);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				track_sample(s_tuser, s_tdata);
			pending <= angle_q.size();
		end
	end

endmodule

[tb/sv/tb_imu_complementary_attitude_filter_core.sv]
`timescale 1ns / 100ps
module tb_imu_complementary_attitude_filter_core;
	import iacf_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	wire         s_tready;
	logic [95:0] s_tdata;   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
	logic [2:0]  s_tuser;   // sensor_slot
	wire         m_tvalid;
	logic        m_tready;
	wire [95:0]  m_tdata;   // roll_angle, pitch_angle, yaw_angle
	wire [2:0]   m_tuser;   // result_slot
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	wire [31:0]  prdata;
	wire         pready;
	int          fail_count;
	int          pending;

	imu_complementary_attitude_filter_core uut (.*);

	iacf_checker chk (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid,
		.m_tready, .m_tdata, .m_tuser, .psel, .penable, .pwrite, .paddr, .pwdata,
		.fail_count, .pending
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	// receiver: random stalls, with stall-free stretches
	initial begin
		int gap;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			repeat (gap) @(posedge clk);
			m_tready <= 1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			m_tready <= 0;
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		@(posedge clk);
	endtask

	task automatic send_word(logic [2:0] s, logic [95:0] d, bit pace);
		int n;
		n = pace ? int'($urandom_range(0, 14)) : 0;
		if (n != 0) begin
			s_tvalid <= 0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= s;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0 || m_tvalid)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic logic [15:0] axis_val();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(0, 200)) - 100);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [95:0] rand_sample();
		return {axis_val(), axis_val(), axis_val(), axis_val(), axis_val(), axis_val()};
	endfunction

	initial begin
		logic [2:0] s;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: zero vector seed, extremes, vertical axes
		send_word(3'd0, '0, 0);
		send_word(3'd1, {48'h0, 16'h7fff, 16'h0, 16'h0}, 0);
		send_word(3'd2, {48'h0, 16'h8000, 16'h0, 16'h0}, 0);
		send_word(3'd3, {48'h0, 16'h0, 16'h7fff, 16'h0}, 0);
		send_word(3'd4, {48'h0, 16'h0, 16'h0, 16'h8000}, 0);
		send_word(3'd5, {16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, 0);
		for (int k = 0; k < 26; k++)
			send_word(3'd0, {16'h7fff, 16'h8000, 16'h7fff, 16'h0, 16'h8000, 16'h7fff}, 1);
		send_word(3'd0, {48'h0, 48'h0}, 0);
		send_word(3'd0, {48'h7fff_8000_7fff, 16'h8000, 16'h8000, 16'h0}, 0);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					reg_write(REG_ACCEL_WEIGHT, 32'd0);
					reg_write(REG_BLEND_WEIGHT, 32'd65535);
					reg_write(REG_GYRO_SCALE, 32'hffffffff);
				end
				1: begin
					reg_write(REG_ACCEL_WEIGHT, 32'd65535);
					reg_write(REG_BLEND_WEIGHT, 32'd0);
					reg_write(REG_GYRO_SCALE, 32'd0);
				end
				2: begin
					reg_write(REG_ACCEL_WEIGHT, $urandom_range(0, 65535));
					reg_write(REG_BLEND_WEIGHT, $urandom_range(0, 65535));
					reg_write(REG_GYRO_SCALE, $urandom);
				end
				default: begin
					reg_write(REG_ACCEL_WEIGHT, {16'h0, ACCEL_WEIGHT_RST});
					reg_write(REG_BLEND_WEIGHT, {16'h0, BLEND_WEIGHT_RST});
					reg_write(REG_GYRO_SCALE, GYRO_SCALE_RST);
				end
			endcase
			for (int k = 0; k < 130; k++) begin
				s = ($urandom_range(0, 2) == 0) ? 3'($urandom) : 3'($urandom_range(0, 2));
				send_word(s, rand_sample(), $urandom_range(0, 2) != 0);
				if (ph == 1 && k == 60) begin
					s_tvalid <= 0;
					@(posedge clk);
					while (pending != 0)
						@(posedge clk);
				end
			end
			drain();
		end
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
